// File: design/gr2m_pkg.sv
// Shared constants and types for the gamepad report to MIDI event block.
`timescale 1ns / 1ps
package gr2m_pkg;

  // Buttons in use; bits above are ignored and stored as zero.
  localparam int unsigned BUTTON_COUNT = 16;
  localparam int unsigned BUTTON_W     = 16;
  localparam logic [BUTTON_W-1:0] BUTTON_MASK =
    BUTTON_W'((33'd1 << BUTTON_COUNT) - 33'd1);

  // Event slots: buttons, then left/right stick, then left/right trigger.
  localparam int unsigned EVT_SLOTS   = BUTTON_W + 4;
  localparam int unsigned SLOT_W      = $clog2(EVT_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_STICK_L = SLOT_W'(BUTTON_W);
  localparam logic [SLOT_W-1:0] SLOT_STICK_R = SLOT_W'(BUTTON_W + 1);
  localparam logic [SLOT_W-1:0] SLOT_TRIG_L  = SLOT_W'(BUTTON_W + 2);
  localparam logic [SLOT_W-1:0] SLOT_TRIG_R  = SLOT_W'(BUTTON_W + 3);

  // Note offsets from the stick base note.
  localparam logic [3:0] OFS_STICK_R = 4'd4;
  localparam logic [3:0] OFS_TRIG_L  = 4'd8;
  localparam logic [3:0] OFS_TRIG_R  = 4'd9;

  localparam logic [7:0] STATUS_ON   = 8'h90;
  localparam logic [7:0] STATUS_OFF  = 8'h80;
  localparam logic [7:0] AXIS_CENTER = 8'd128;

  // Direction codes.
  localparam logic [2:0] DIR_NEUTRAL = 3'd0;
  localparam logic [2:0] DIR_UP      = 3'd1;
  localparam logic [2:0] DIR_DOWN    = 3'd2;
  localparam logic [2:0] DIR_LEFT    = 3'd3;
  localparam logic [2:0] DIR_RIGHT   = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_BASE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_STICK_BASE  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ON_VELOCITY = CFG_IDX_W'(3);

  localparam logic [6:0] RST_DEAD_ZONE   = 7'd8;
  localparam logic [6:0] RST_BUTTON_BASE = 7'd60;
  localparam logic [6:0] RST_STICK_BASE  = 7'd40;
  localparam logic [6:0] RST_ON_VELOCITY = 7'd127;

  typedef struct packed {
    logic [6:0] dead_zone;
    logic [6:0] button_base_note;
    logic [6:0] stick_base_note;
    logic [6:0] on_velocity;
  } cfg_t;

  // One message request from the sequencer to the note unit.
  typedef struct packed {
    logic       load;
    logic       use_stick;
    logic [3:0] offset;
    logic       on;
    logic       last;
  } emit_req_t;

endpackage

// File: design/gr2m_ifs.sv
// Handshake channels: report in, event out, configuration write.
`timescale 1ns / 1ps
interface gr2m_report_if;
  logic        valid;
  logic        ready;
  logic [7:0]  left_x;
  logic [7:0]  left_y;
  logic [7:0]  right_x;
  logic [7:0]  right_y;
  logic [15:0] buttons;
  logic [7:0]  left_trigger;
  logic [7:0]  right_trigger;

  modport source (output valid, left_x, left_y, right_x, right_y, buttons,
                  left_trigger, right_trigger, input ready);
  modport sink (input valid, left_x, left_y, right_x, right_y, buttons,
                left_trigger, right_trigger, output ready);
endinterface

interface gr2m_event_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [6:0] note;
  logic [6:0] velocity;
  logic       last;

  modport source (output valid, status_byte, note, velocity, last, input ready);
  modport sink (input valid, status_byte, note, velocity, last, output ready);
endinterface

interface gr2m_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [6:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/gr2m_cfg_regs.sv
// Configuration register file written through the config channel.
`timescale 1ns / 1ps
module gr2m_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  gr2m_cfg_if.sink       cfg_i,
  output gr2m_pkg::cfg_t cfg_o
);

  gr2m_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_zone        <= gr2m_pkg::RST_DEAD_ZONE;
      cfg_q.button_base_note <= gr2m_pkg::RST_BUTTON_BASE;
      cfg_q.stick_base_note  <= gr2m_pkg::RST_STICK_BASE;
      cfg_q.on_velocity      <= gr2m_pkg::RST_ON_VELOCITY;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        gr2m_pkg::REG_DEAD_ZONE:   cfg_q.dead_zone        <= cfg_i.data;
        gr2m_pkg::REG_BUTTON_BASE: cfg_q.button_base_note <= cfg_i.data;
        gr2m_pkg::REG_STICK_BASE:  cfg_q.stick_base_note  <= cfg_i.data;
        gr2m_pkg::REG_ON_VELOCITY: cfg_q.on_velocity      <= cfg_i.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

// File: design/gr2m_class.sv
// Stick direction classifier: x before y, center 128 with a dead zone.
`timescale 1ns / 1ps
module gr2m_class (
  input  logic [7:0] x_i,
  input  logic [7:0] y_i,
  input  logic [6:0] dead_zone_i,
  output logic [2:0] dir_o
);

  logic [7:0] lo;
  logic [7:0] hi;

  // 128 - dz stays in 1..128 and 128 + dz in 128..255
  assign lo = gr2m_pkg::AXIS_CENTER - {1'b0, dead_zone_i};
  assign hi = gr2m_pkg::AXIS_CENTER + {1'b0, dead_zone_i};

  always_comb begin
    if (x_i < lo) begin
      dir_o = gr2m_pkg::DIR_LEFT;
    end else if (x_i > hi) begin
      dir_o = gr2m_pkg::DIR_RIGHT;
    end else if (y_i < lo) begin
      dir_o = gr2m_pkg::DIR_UP;
    end else if (y_i > hi) begin
      dir_o = gr2m_pkg::DIR_DOWN;
    end else begin
      dir_o = gr2m_pkg::DIR_NEUTRAL;
    end
  end

endmodule

// File: design/gr2m_note_unit.sv
// Shared note adder and output register for one event beat.
`timescale 1ns / 1ps
module gr2m_note_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gr2m_pkg::cfg_t      cfg_i,
  input  gr2m_pkg::emit_req_t req_i,
  output logic                free_o,
  gr2m_event_if.source        evt_o
);

  logic       valid_q;
  logic [7:0] status_q;
  logic [6:0] note_q;
  logic [6:0] vel_q;
  logic       last_q;
  logic [6:0] base;
  logic [6:0] note_d;

  assign free_o = !valid_q || evt_o.ready;
  assign base   = req_i.use_stick ? cfg_i.stick_base_note : cfg_i.button_base_note;
  // wrap to 7 bits
  assign note_d = base + {3'b000, req_i.offset};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.load) begin
      valid_q <= 1'b1;
    end else if (evt_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      status_q <= req_i.on ? gr2m_pkg::STATUS_ON : gr2m_pkg::STATUS_OFF;
      note_q   <= note_d;
      vel_q    <= req_i.on ? cfg_i.on_velocity : 7'd0;
      last_q   <= req_i.last;
    end
  end

  assign evt_o.valid       = valid_q;
  assign evt_o.status_byte = status_q;
  assign evt_o.note        = note_q;
  assign evt_o.velocity    = vel_q;
  assign evt_o.last        = last_q;

endmodule

// File: design/gr2m_seq.sv
// Sequencer: captures a report, finds pending events, walks them in order.
`timescale 1ns / 1ps
module gr2m_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gr2m_pkg::cfg_t       cfg_i,
  gr2m_report_if.sink          report_i,
  input  logic                 free_i,
  output gr2m_pkg::emit_req_t  req_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLASS = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  localparam int unsigned NS = gr2m_pkg::EVT_SLOTS;
  localparam int unsigned SW = gr2m_pkg::SLOT_W;
  localparam int unsigned BW = gr2m_pkg::BUTTON_W;

  logic [1:0]    state_q, state_d;

  // captured report
  logic [7:0]    lx_q, ly_q, rx_q, ry_q, lt_q, rt_q;
  logic [BW-1:0] btn_q;

  // persistent state
  logic [BW-1:0] prev_btn_q;
  logic [2:0]    ldir_q, rdir_q;
  logic          lheld_q, rheld_q;

  // work list of the current report
  logic [NS-1:0] pend_q, pend_d;
  logic [NS-1:0] on_q, on_d;

  logic [2:0]    ldir_new, rdir_new;
  logic          lt_nz, rt_nz;
  logic [SW-1:0] idx;
  logic [NS-1:0] rest;
  logic [2:0]    dir_m1_l, dir_m1_r;

  gr2m_class u_class_l (
    .x_i         (lx_q),
    .y_i         (ly_q),
    .dead_zone_i (cfg_i.dead_zone),
    .dir_o       (ldir_new)
  );

  gr2m_class u_class_r (
    .x_i         (rx_q),
    .y_i         (ry_q),
    .dead_zone_i (cfg_i.dead_zone),
    .dir_o       (rdir_new)
  );

  assign lt_nz = (lt_q != 8'd0);
  assign rt_nz = (rt_q != 8'd0);
  assign report_i.ready = (state_q == S_IDLE);

  always_comb begin
    pend_d = '0;
    on_d   = '0;
    pend_d[BW-1:0] = (btn_q & gr2m_pkg::BUTTON_MASK) ^ prev_btn_q;
    on_d[BW-1:0]   = btn_q & gr2m_pkg::BUTTON_MASK;
    pend_d[gr2m_pkg::SLOT_STICK_L] = (ldir_new != ldir_q) &&
                                     (ldir_new != gr2m_pkg::DIR_NEUTRAL);
    pend_d[gr2m_pkg::SLOT_STICK_R] = (rdir_new != rdir_q) &&
                                     (rdir_new != gr2m_pkg::DIR_NEUTRAL);
    pend_d[gr2m_pkg::SLOT_TRIG_L]  = lt_nz != lheld_q;
    pend_d[gr2m_pkg::SLOT_TRIG_R]  = rt_nz != rheld_q;
    on_d[gr2m_pkg::SLOT_STICK_L]   = 1'b1;
    on_d[gr2m_pkg::SLOT_STICK_R]   = 1'b1;
    on_d[gr2m_pkg::SLOT_TRIG_L]    = lt_nz;
    on_d[gr2m_pkg::SLOT_TRIG_R]    = rt_nz;
  end

  // lowest pending slot goes next
  always_comb begin
    idx = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        idx = SW'(i);
      end
    end
  end

  assign rest     = pend_q & ~(NS'(1) << idx);
  assign dir_m1_l = ldir_q - 3'd1;
  assign dir_m1_r = rdir_q - 3'd1;

  always_comb begin
    req_o.load      = (state_q == S_EMIT) && free_i;
    req_o.on        = on_q[idx];
    req_o.last      = (rest == '0);
    req_o.use_stick = 1'b1;
    req_o.offset    = '0;
    case (idx)
      gr2m_pkg::SLOT_STICK_L: req_o.offset = {1'b0, dir_m1_l};
      gr2m_pkg::SLOT_STICK_R: req_o.offset = gr2m_pkg::OFS_STICK_R + {1'b0, dir_m1_r};
      gr2m_pkg::SLOT_TRIG_L:  req_o.offset = gr2m_pkg::OFS_TRIG_L;
      gr2m_pkg::SLOT_TRIG_R:  req_o.offset = gr2m_pkg::OFS_TRIG_R;
      default: begin
        req_o.use_stick = 1'b0;
        req_o.offset    = idx[3:0];
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (report_i.valid) begin
          state_d = S_CLASS;
        end
      end
      S_CLASS: begin
        state_d = (pend_d == '0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (free_i && rest == '0) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      prev_btn_q <= '0;
      ldir_q     <= gr2m_pkg::DIR_NEUTRAL;
      rdir_q     <= gr2m_pkg::DIR_NEUTRAL;
      lheld_q    <= 1'b0;
      rheld_q    <= 1'b0;
      pend_q     <= '0;
      on_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLASS) begin
        prev_btn_q <= btn_q & gr2m_pkg::BUTTON_MASK;
        ldir_q     <= ldir_new;
        rdir_q     <= rdir_new;
        lheld_q    <= lt_nz;
        rheld_q    <= rt_nz;
        pend_q     <= pend_d;
        on_q       <= on_d;
      end else if (req_o.load) begin
        pend_q <= rest;
      end
    end
  end

  // capture report payload on accept
  always_ff @(posedge clk_i) begin
    if (report_i.valid && report_i.ready) begin
      lx_q  <= report_i.left_x;
      ly_q  <= report_i.left_y;
      rx_q  <= report_i.right_x;
      ry_q  <= report_i.right_y;
      btn_q <= report_i.buttons;
      lt_q  <= report_i.left_trigger;
      rt_q  <= report_i.right_trigger;
    end
  end

endmodule

// File: design/gamepad_report_to_midi_events.sv
// Top level: gamepad report in, MIDI note event beats out.
`timescale 1ns / 1ps
// Each accepted report is captured, classified in the next cycle, and then its
// messages leave one beat per cycle while the sink holds ready high: buttons in
// ascending order, left stick, right stick, left trigger, right trigger, with last
// set on the final beat. A report gives 0 to 20 messages, and the next report is
// accepted only after its final beat is loaded; the single note adder and the
// one-deep event register set the pace. A report that changes nothing gives no
// beat. Configuration writes are taken at any time but belong in idle periods.
module gamepad_report_to_midi_events (
  input  logic         clk_i,
  input  logic         rst_ni,
  gr2m_report_if.sink  report_i,
  gr2m_event_if.source evt_o,
  gr2m_cfg_if.sink     cfg_i
);

  gr2m_pkg::cfg_t      cfg;
  gr2m_pkg::emit_req_t req;
  logic                free;

  gr2m_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  gr2m_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .report_i (report_i),
    .free_i   (free),
    .req_o    (req)
  );

  gr2m_note_unit u_note (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req),
    .free_o (free),
    .evt_o  (evt_o)
  );

endmodule

// File: test/tb_gamepad_report_to_midi_events.sv
// Self-checking testbench for the gamepad report to MIDI note event block.
`timescale 1ns / 1ps
module tb_gamepad_report_to_midi_events;

  localparam logic [gr2m_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO =
    gr2m_pkg::REG_ON_VELOCITY + 1'b1;
  localparam logic [gr2m_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = '1;

  typedef struct packed {
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [15:0] buttons;
    logic [7:0]  left_trigger;
    logic [7:0]  right_trigger;
  } report_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] note;
    logic [6:0] velocity;
    logic       last;
  } midi_note_t;

  // Tracks controller state and the note beats each report should produce.
  class midi_note_checker;
    gr2m_pkg::cfg_t cfg;
    logic [15:0]    held_buttons;
    logic [2:0]     lstick_dir;
    logic [2:0]     rstick_dir;
    logic           left_held;
    logic           right_held;
    midi_note_t     expected_notes[$];
    int             errors;

    function new();
      cfg = '{gr2m_pkg::RST_DEAD_ZONE, gr2m_pkg::RST_BUTTON_BASE,
              gr2m_pkg::RST_STICK_BASE, gr2m_pkg::RST_ON_VELOCITY};
      held_buttons = '0;
      lstick_dir = gr2m_pkg::DIR_NEUTRAL;
      rstick_dir = gr2m_pkg::DIR_NEUTRAL;
      left_held = 1'b0;
      right_held = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [gr2m_pkg::CFG_IDX_W-1:0] idx, logic [6:0] val);
      case (idx)
        gr2m_pkg::REG_DEAD_ZONE:   cfg.dead_zone = val;
        gr2m_pkg::REG_BUTTON_BASE: cfg.button_base_note = val;
        gr2m_pkg::REG_STICK_BASE:  cfg.stick_base_note = val;
        gr2m_pkg::REG_ON_VELOCITY: cfg.on_velocity = val;
        default: ;
      endcase
    endfunction

    function void push_note(logic on, int note);
      midi_note_t n;
      n.status_byte = on ? gr2m_pkg::STATUS_ON : gr2m_pkg::STATUS_OFF;
      n.note = 7'(note);
      n.velocity = on ? cfg.on_velocity : 7'd0;
      n.last = 1'b0;
      expected_notes.push_back(n);
    endfunction

    function logic [2:0] classify(logic [7:0] x, logic [7:0] y);
      int lo, hi;
      lo = int'(gr2m_pkg::AXIS_CENTER) - int'(cfg.dead_zone);
      hi = int'(gr2m_pkg::AXIS_CENTER) + int'(cfg.dead_zone);
      if (int'(x) < lo) return gr2m_pkg::DIR_LEFT;
      if (int'(x) > hi) return gr2m_pkg::DIR_RIGHT;
      if (int'(y) < lo) return gr2m_pkg::DIR_UP;
      if (int'(y) > hi) return gr2m_pkg::DIR_DOWN;
      return gr2m_pkg::DIR_NEUTRAL;
    endfunction

    // Going back to neutral updates the state silently.
    function void stick_note(logic [2:0] was, logic [2:0] now, logic [3:0] group);
      if (now != was && now != gr2m_pkg::DIR_NEUTRAL)
        push_note(1'b1, int'(cfg.stick_base_note) + int'(group) + int'(now) - 1);
    endfunction

    function logic trigger_step(logic held, logic [7:0] value, logic [3:0] ofs);
      if (value != 0 && !held) begin
        push_note(1'b1, int'(cfg.stick_base_note) + int'(ofs));
        return 1'b1;
      end
      if (value == 0 && held) begin
        push_note(1'b0, int'(cfg.stick_base_note) + int'(ofs));
        return 1'b0;
      end
      return held;
    endfunction

    function void take_report(report_t r);
      int          start;
      logic [15:0] now;
      logic [2:0]  dir;
      start = expected_notes.size();
      now = r.buttons & gr2m_pkg::BUTTON_MASK;
      for (int i = 0; i < gr2m_pkg::BUTTON_COUNT; i++) begin
        if (now[i] != held_buttons[i])
          push_note(now[i], int'(cfg.button_base_note) + i);
      end
      held_buttons = now;
      dir = classify(r.left_x, r.left_y);
      stick_note(lstick_dir, dir, 4'd0);
      lstick_dir = dir;
      dir = classify(r.right_x, r.right_y);
      stick_note(rstick_dir, dir, gr2m_pkg::OFS_STICK_R);
      rstick_dir = dir;
      left_held = trigger_step(left_held, r.left_trigger, gr2m_pkg::OFS_TRIG_L);
      right_held = trigger_step(right_held, r.right_trigger, gr2m_pkg::OFS_TRIG_R);
      if (expected_notes.size() > start)
        expected_notes[expected_notes.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_note(midi_note_t got);
      midi_note_t want;
      if (expected_notes.size() == 0) begin
        $error("unexpected beat: status %0h note %0d velocity %0d last %0b",
               got.status_byte, got.note, got.velocity, got.last);
        errors++;
        return;
      end
      want = expected_notes.pop_front();
      compare_field("status_byte", want.status_byte, got.status_byte);
      compare_field("note", 8'(want.note), 8'(got.note));
      compare_field("velocity", 8'(want.velocity), 8'(got.velocity));
      compare_field("last", 8'(want.last), 8'(got.last));
    endfunction

    function int pending();
      return expected_notes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic recv_hold;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic [15:0] last_buttons;

  midi_note_checker sb = new();

  gr2m_report_if report_if();
  gr2m_event_if  evt_if();
  gr2m_cfg_if    cfg_if();

  gamepad_report_to_midi_events i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .report_i (report_if),
    .evt_o    (evt_if),
    .cfg_i    (cfg_if)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Check accepted beats and drive ready with random stalls.
  always @(posedge clk) begin
    if (rst_n && evt_if.valid && evt_if.ready)
      sb.check_note('{evt_if.status_byte, evt_if.note, evt_if.velocity, evt_if.last});
    evt_if.ready <= !recv_hold && (int'($urandom_range(99)) >= recv_idle_pct);
  end

  function automatic report_t report(input logic [7:0] lx, input logic [7:0] ly,
                                     input logic [7:0] rx, input logic [7:0] ry,
                                     input logic [15:0] btn, input logic [7:0] lt,
                                     input logic [7:0] rt);
    report_t r;
    r = '{lx, ly, rx, ry, btn, lt, rt};
    return r;
  endfunction

  // Bias axes toward the neutral band and its edges.
  function automatic logic [7:0] rand_axis(input int dz);
    int v;
    case ($urandom_range(3))
      0: v = 128 - dz + int'($urandom_range(2 * dz));
      1: v = $urandom_range(1) ? 127 - dz + int'($urandom_range(2))
                               : 127 + dz + int'($urandom_range(2));
      2: v = $urandom_range(255);
      default: v = $urandom_range(1) ? 0 : 255;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [7:0] rand_trigger();
    return ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
  endfunction

  function automatic report_t rand_report();
    report_t r;
    int      dz;
    dz = sb.cfg.dead_zone;
    r.left_x = rand_axis(dz);
    r.left_y = rand_axis(dz);
    r.right_x = rand_axis(dz);
    r.right_y = rand_axis(dz);
    case ($urandom_range(4))
      0:       r.buttons = last_buttons;
      1, 2:    r.buttons = last_buttons ^ (16'd1 << $urandom_range(15));
      3:       r.buttons = last_buttons ^ 16'($urandom);
      default: r.buttons = 16'($urandom);
    endcase
    r.left_trigger = rand_trigger();
    r.right_trigger = rand_trigger();
    return r;
  endfunction

  task automatic send_report(input report_t r);
    if (int'($urandom_range(99)) < send_idle_pct) begin
      report_if.valid <= 1'b0;
      do @(posedge clk); while (int'($urandom_range(99)) < send_idle_pct);
    end
    report_if.valid <= 1'b1;
    report_if.left_x <= r.left_x;
    report_if.left_y <= r.left_y;
    report_if.right_x <= r.right_x;
    report_if.right_y <= r.right_y;
    report_if.buttons <= r.buttons;
    report_if.left_trigger <= r.left_trigger;
    report_if.right_trigger <= r.right_trigger;
    do @(posedge clk); while (!report_if.ready);
    sb.take_report(r);
    last_buttons = r.buttons;
  endtask

  // Drain all expected beats, then let a silent report finish.
  task automatic wait_idle();
    report_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs(input logic [6:0] dz, input logic [6:0] bbase,
                              input logic [6:0] sbase, input logic [6:0] vel,
                              input logic [gr2m_pkg::CFG_IDX_W-1:0] unmapped);
    logic [gr2m_pkg::CFG_IDX_W-1:0] idx[5];
    logic [6:0]                     val[5];
    idx = '{gr2m_pkg::REG_DEAD_ZONE, gr2m_pkg::REG_BUTTON_BASE, gr2m_pkg::REG_STICK_BASE,
            gr2m_pkg::REG_ON_VELOCITY, unmapped};
    val = '{dz, bbase, sbase, vel, 7'($urandom)};
    for (int i = 0; i < 5; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data <= val[i];
      do @(posedge clk); while (!cfg_if.ready);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic hold_events(input int cycles);
    recv_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    recv_hold <= 1'b0;
  endtask

  task automatic random_reports(input int count, input bit pause_midway);
    for (int i = 0; i < count; i++) begin
      send_report(rand_report());
      if (pause_midway && i == count / 2) wait_idle();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    recv_hold = 1'b0;
    last_buttons = '0;
    send_idle_pct = 16;
    recv_idle_pct = 54;
    report_if.valid = 1'b0;
    report_if.left_x = '0;
    report_if.left_y = '0;
    report_if.right_x = '0;
    report_if.right_y = '0;
    report_if.buttons = '0;
    report_if.left_trigger = '0;
    report_if.right_trigger = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    evt_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: silent report, full burst, x before y, band edges.
    send_report(report(8'd128, 8'd128, 8'd128, 8'd128, 16'h0000, 8'd0, 8'd0));
    send_report(report(8'd0, 8'd128, 8'd255, 8'd128, 16'hFFFF, 8'd255, 8'd255));
    send_report(report(8'd0, 8'd128, 8'd255, 8'd128, 16'hFFFF, 8'd255, 8'd255));
    send_report(report(8'd128, 8'd0, 8'd128, 8'd255, 16'hFFFF, 8'd255, 8'd255));
    send_report(report(8'd0, 8'd0, 8'd128, 8'd128, 16'hFFFF, 8'd255, 8'd255));
    send_report(report(8'd120, 8'd128, 8'd136, 8'd128, 16'hFFFF, 8'd255, 8'd255));
    send_report(report(8'd119, 8'd128, 8'd137, 8'd128, 16'hFFFF, 8'd255, 8'd255));
    send_report(report(8'd128, 8'd120, 8'd128, 8'd136, 16'hFFFF, 8'd255, 8'd255));
    send_report(report(8'd128, 8'd119, 8'd128, 8'd137, 16'hFFFF, 8'd255, 8'd255));
    send_report(report(8'd128, 8'd128, 8'd128, 8'd128, 16'h0000, 8'd0, 8'd0));
    send_report(report(8'd128, 8'd128, 8'd128, 8'd128, 16'hAAAA, 8'd1, 8'd0));
    send_report(report(8'd128, 8'd128, 8'd128, 8'd128, 16'h5555, 8'd0, 8'd1));
    send_report(report(8'd128, 8'd128, 8'd128, 8'd128, 16'h0001, 8'd128, 8'd128));
    send_report(report(8'd255, 8'd255, 8'd0, 8'd0, 16'h8000, 8'd0, 8'd0));
    wait_idle();

    // Low extremes of the band, notes wrapping past 127, zero velocity.
    program_regs(7'd0, 7'd127, 7'd127, 7'd0, REG_UNMAPPED_LO);
    send_report(report(8'd127, 8'd128, 8'd129, 8'd128, 16'hFFFF, 8'd1, 8'd1));
    send_report(report(8'd128, 8'd127, 8'd128, 8'd129, 16'h0000, 8'd0, 8'd0));
    send_report(report(8'd128, 8'd128, 8'd128, 8'd128, 16'h00F0, 8'd0, 8'd0));
    random_reports(50, 1'b0);
    wait_idle();

    send_idle_pct = 54;
    recv_idle_pct = 16;
    program_regs(7'd127, 7'd0, 7'd0, 7'd85, REG_UNMAPPED_HI);
    send_report(report(8'd0, 8'd0, 8'd255, 8'd255, 16'h0F0F, 8'd7, 8'd0));
    send_report(report(8'd1, 8'd0, 8'd128, 8'd0, 16'hF0F0, 8'd0, 8'd9));
    // Stall the event side while reports keep coming.
    fork
      hold_events(400);
    join_none
    random_reports(50, 1'b0);
    wait_idle();

    program_regs(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom),
                 8'($urandom_range(255, int'(REG_UNMAPPED_LO))));
    random_reports(50, 1'b1);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(gr2m_pkg::RST_DEAD_ZONE, gr2m_pkg::RST_BUTTON_BASE,
                 gr2m_pkg::RST_STICK_BASE, 7'd42, REG_UNMAPPED_LO);
    random_reports(50, 1'b0);
    wait_idle();

    if (sb.errors == 0) begin
      $display("tb_gamepad_report_to_midi_events: PASS");
    end else begin
      $display("tb_gamepad_report_to_midi_events: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_gamepad_report_to_midi_events: FAIL");
    $finish;
  end

endmodule

// File: gamepad_report_to_midi_events.f
design/gr2m_pkg.sv
design/gr2m_ifs.sv
design/gr2m_cfg_regs.sv
design/gr2m_class.sv
design/gr2m_note_unit.sv
design/gr2m_seq.sv
design/gamepad_report_to_midi_events.sv
test/tb_gamepad_report_to_midi_events.sv
